// ===== rtl/modular_gray_code_generator_assert.svh =====
// assertion macros for the modular gray code generator
// both expect aclk and aresetn in the scope where they are used
`ifndef MODULAR_GRAY_CODE_GENERATOR_ASSERT_SVH
`define MODULAR_GRAY_CODE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MGC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mgc: same-cycle check failed");

// next-cycle implication
`define MGC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mgc: next-cycle check failed");

`endif

// ===== rtl/mgc_pkg.sv =====
package mgc_pkg;

    // field and register widths
    localparam int ALPHA_W    = 5;
    localparam int WLEN_W     = 4;
    localparam int LIMIT_W    = 32;
    localparam int RANK_W     = 32;
    localparam int CODE_W     = 32;
    localparam int CHG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_BITS   = CODE_W + CHG_W + LIMIT_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // parameter defaults
    localparam int MAX_DIGITS_DEF = 8;
    localparam int DIGIT_BITS_DEF = 4;

    // divider: quotient bits per cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_CHUNKS = RANK_W / DIV_BITS;
    localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

    // register reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 5'd3;
    localparam logic [WLEN_W-1:0]  WLEN_RST  = 4'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 32'd26;

    // item kinds
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_ADV_INIT,
        OP_RIPPLE,
        OP_BUMP,
        OP_LOAD_INIT,
        OP_DIV,
        OP_DIGIT,
        OP_PACK_INIT,
        OP_PACK,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_LOAD,
        COND_FINISHED,
        COND_CARRY,
        COND_DIV_MORE,
        COND_DIGIT_MORE,
        COND_PACK_MORE
    } cond_t;

    localparam int PC_W = 4;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    // status flags from datapath to sequencer
    typedef struct packed {
        logic is_load;
        logic finished;
        logic carry;
        logic div_last;
        logic idx_zero;
        logic idx_last;
    } stat_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH  = 4'd1;
    localparam logic [PC_W-1:0] PC_ADV       = 4'd2;
    localparam logic [PC_W-1:0] PC_RIPPLE    = 4'd3;
    localparam logic [PC_W-1:0] PC_BUMP      = 4'd4;
    localparam logic [PC_W-1:0] PC_LOAD      = 4'd5;
    localparam logic [PC_W-1:0] PC_DIV       = 4'd6;
    localparam logic [PC_W-1:0] PC_DIGIT     = 4'd7;
    localparam logic [PC_W-1:0] PC_PACK_INIT = 4'd8;
    localparam logic [PC_W-1:0] PC_PACK      = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT      = 4'd10;

    // control store
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_WAIT};
        case (pc)
            PC_WAIT:      w = '{op: OP_WAIT,      cond: COND_NONE,       target: PC_WAIT};
            PC_DISPATCH:  w = '{op: OP_NOP,       cond: COND_LOAD,       target: PC_LOAD};
            PC_ADV:       w = '{op: OP_ADV_INIT,  cond: COND_FINISHED,   target: PC_PACK_INIT};
            PC_RIPPLE:    w = '{op: OP_RIPPLE,    cond: COND_CARRY,      target: PC_RIPPLE};
            PC_BUMP:      w = '{op: OP_BUMP,      cond: COND_ALWAYS,     target: PC_PACK_INIT};
            PC_LOAD:      w = '{op: OP_LOAD_INIT, cond: COND_NONE,       target: PC_WAIT};
            PC_DIV:       w = '{op: OP_DIV,       cond: COND_DIV_MORE,   target: PC_DIV};
            PC_DIGIT:     w = '{op: OP_DIGIT,     cond: COND_DIGIT_MORE, target: PC_DIV};
            PC_PACK_INIT: w = '{op: OP_PACK_INIT, cond: COND_NONE,       target: PC_WAIT};
            PC_PACK:      w = '{op: OP_PACK,      cond: COND_PACK_MORE,  target: PC_PACK};
            PC_EMIT:      w = '{op: OP_EMIT,      cond: COND_ALWAYS,     target: PC_WAIT};
            default:      w = '{op: OP_NOP,       cond: COND_ALWAYS,     target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/mgc_sequencer.sv =====
module mgc_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           out_free,
    input  mgc_pkg::stat_t stat,
    output mgc_pkg::op_t   op
);

    logic [mgc_pkg::PC_W-1:0] pc_reg;
    logic [mgc_pkg::PC_W-1:0] pc_next;
    mgc_pkg::ucode_t          uc;
    logic                     hold;
    logic                     jump;

    assign uc = mgc_pkg::ucode_rom(pc_reg);
    assign op = uc.op;

    // wait states stall on the handshakes
    assign hold = ((uc.op == mgc_pkg::OP_WAIT) && !in_valid) ||
                  ((uc.op == mgc_pkg::OP_EMIT) && !out_free);

    always_comb begin
        case (uc.cond)
            mgc_pkg::COND_NONE:       jump = 1'b0;
            mgc_pkg::COND_ALWAYS:     jump = 1'b1;
            mgc_pkg::COND_LOAD:       jump = stat.is_load;
            mgc_pkg::COND_FINISHED:   jump = stat.finished;
            mgc_pkg::COND_CARRY:      jump = stat.carry;
            mgc_pkg::COND_DIV_MORE:   jump = !stat.div_last;
            mgc_pkg::COND_DIGIT_MORE: jump = !stat.idx_zero;
            mgc_pkg::COND_PACK_MORE:  jump = !stat.idx_last;
            default:                  jump = 1'b1;
        endcase
    end

    always_comb begin
        if (hold) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = uc.target;
        end else begin
            pc_next = pc_reg + mgc_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= mgc_pkg::PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/mgc_datapath.sv =====
module mgc_datapath #(
    parameter int MAX_DIGITS = mgc_pkg::MAX_DIGITS_DEF,
    parameter int DIGIT_BITS = mgc_pkg::DIGIT_BITS_DEF,
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mgc_pkg::op_t                 op,
    input  logic                         in_fire,
    input  logic                         in_mode,
    input  logic [mgc_pkg::RANK_W-1:0]   in_rank,
    input  logic [mgc_pkg::ALPHA_W-1:0]  m_eff,
    input  logic [IDX_W-1:0]             n_m1,
    input  logic [mgc_pkg::LIMIT_W-1:0]  step_limit,
    output mgc_pkg::stat_t               stat,
    output logic [mgc_pkg::CODE_W-1:0]   codeword,
    output logic [mgc_pkg::CHG_W-1:0]    changed,
    output logic [mgc_pkg::LIMIT_W-1:0]  steps,
    output logic                         finished
);

    localparam int VAL_W = (DIGIT_BITS + 1 > mgc_pkg::ALPHA_W) ? DIGIT_BITS + 1
                                                              : mgc_pkg::ALPHA_W;
    localparam logic [mgc_pkg::CHUNK_W-1:0] CHUNK_LAST =
        mgc_pkg::CHUNK_W'(mgc_pkg::DIV_CHUNKS - 1);

    logic [DIGIT_BITS-1:0]          gray_reg [MAX_DIGITS];
    logic [DIGIT_BITS-1:0]          gray_next[MAX_DIGITS];
    logic [DIGIT_BITS-1:0]          cnt_reg  [MAX_DIGITS];
    logic [DIGIT_BITS-1:0]          cnt_next [MAX_DIGITS];
    logic [mgc_pkg::RANK_W-1:0]     r_reg,     r_next;
    logic [mgc_pkg::ALPHA_W-1:0]    rem_reg,   rem_next;
    logic [DIGIT_BITS-1:0]          prev_reg,  prev_next;
    logic [IDX_W-1:0]               idx_reg,   idx_next;
    logic [mgc_pkg::CHUNK_W-1:0]    chunk_reg, chunk_next;
    logic                           mode_reg,  mode_next;
    logic                           wrap_reg,  wrap_next;
    logic [mgc_pkg::CODE_W-1:0]     word_reg,  word_next;
    logic [mgc_pkg::CHG_W-1:0]      chg_reg,   chg_next;
    logic [mgc_pkg::LIMIT_W-1:0]    steps_reg, steps_next;
    logic                           fin_reg,   fin_next;

    // divider chunk
    logic [mgc_pkg::RANK_W-1:0]     quo;
    logic [mgc_pkg::ALPHA_W-1:0]    rem_t;
    logic [mgc_pkg::ALPHA_W:0]      trial;

    // digit arithmetic
    logic [IDX_W-1:0]               idx_inc;
    logic [DIGIT_BITS-1:0]          rem_dig;
    logic [VAL_W:0]                 diff_sum;
    logic [DIGIT_BITS-1:0]          diff_dig;
    logic [VAL_W-1:0]               m_v;
    logic [VAL_W-1:0]               d_inc;
    logic                           d_over;
    logic [VAL_W-1:0]               g_inc;
    logic                           g_over;
    logic [mgc_pkg::LIMIT_W-1:0]    steps_inc;

    always_comb begin
        rem_t = rem_reg;
        quo   = r_reg;
        trial = '0;
        for (int b = 0; b < mgc_pkg::DIV_BITS; b++) begin
            trial = {rem_t, quo[mgc_pkg::RANK_W-1]};
            quo   = {quo[mgc_pkg::RANK_W-2:0], 1'b0};
            if (trial >= {1'b0, m_eff}) begin
                rem_t  = mgc_pkg::ALPHA_W'(trial - {1'b0, m_eff});
                quo[0] = 1'b1;
            end else begin
                rem_t = trial[mgc_pkg::ALPHA_W-1:0];
            end
        end
    end

    assign m_v     = VAL_W'(m_eff);
    assign idx_inc = idx_reg + IDX_W'(1);
    assign rem_dig = DIGIT_BITS'(rem_reg);

    // (prev - rem) mod m, both below m
    always_comb begin
        diff_sum = (VAL_W + 1)'(prev_reg) + (VAL_W + 1)'(m_eff) - (VAL_W + 1)'(rem_reg);
        if (diff_sum >= (VAL_W + 1)'(m_eff)) begin
            diff_sum = diff_sum - (VAL_W + 1)'(m_eff);
        end
        diff_dig = DIGIT_BITS'(diff_sum);
    end

    // a stored digit at or above m counts as m-1
    assign d_inc     = VAL_W'(cnt_reg[idx_reg]) + VAL_W'(1);
    assign d_over    = (d_inc >= m_v);
    assign g_inc     = VAL_W'(gray_reg[idx_reg]) + VAL_W'(1);
    assign g_over    = (g_inc >= m_v);
    assign steps_inc = steps_reg + mgc_pkg::LIMIT_W'(1);

    always_comb begin
        gray_next  = gray_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        rem_next   = rem_reg;
        prev_next  = prev_reg;
        idx_next   = idx_reg;
        chunk_next = chunk_reg;
        mode_next  = mode_reg;
        wrap_next  = wrap_reg;
        word_next  = word_reg;
        chg_next   = chg_reg;
        steps_next = steps_reg;
        fin_next   = fin_reg;
        case (op)
            mgc_pkg::OP_WAIT: begin
                if (in_fire) begin
                    r_next    = in_rank;
                    mode_next = in_mode;
                    chg_next  = '0;
                end
            end
            mgc_pkg::OP_ADV_INIT: begin
                idx_next  = n_m1;
                wrap_next = 1'b0;
            end
            mgc_pkg::OP_RIPPLE: begin
                if (d_over) begin
                    cnt_next[idx_reg] = '0;
                    if (idx_reg == '0) begin
                        wrap_next = 1'b1;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end else begin
                    cnt_next[idx_reg] = DIGIT_BITS'(d_inc);
                end
            end
            mgc_pkg::OP_BUMP: begin
                if (wrap_reg) begin
                    fin_next = 1'b1;
                end else begin
                    gray_next[idx_reg] = g_over ? '0 : DIGIT_BITS'(g_inc);
                    chg_next = mgc_pkg::CHG_W'(32'(idx_reg) + 32'd1);
                end
                steps_next = steps_inc;
                if (steps_inc >= step_limit) begin
                    fin_next = 1'b1;
                end
            end
            mgc_pkg::OP_LOAD_INIT: begin
                for (int i = 0; i < MAX_DIGITS; i++) begin
                    gray_next[i] = '0;
                    cnt_next[i]  = '0;
                end
                idx_next   = n_m1;
                chunk_next = '0;
                rem_next   = '0;
                steps_next = '0;
                fin_next   = (step_limit == '0);
            end
            mgc_pkg::OP_DIV: begin
                r_next     = quo;
                rem_next   = rem_t;
                chunk_next = chunk_reg + mgc_pkg::CHUNK_W'(1);
            end
            mgc_pkg::OP_DIGIT: begin
                cnt_next[idx_reg] = rem_dig;
                if (idx_reg != n_m1) begin
                    gray_next[idx_inc] = diff_dig;
                end
                if (idx_reg == '0) begin
                    gray_next[0] = rem_dig;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
                prev_next  = rem_dig;
                rem_next   = '0;
                chunk_next = '0;
            end
            mgc_pkg::OP_PACK_INIT: begin
                idx_next  = '0;
                word_next = '0;
            end
            mgc_pkg::OP_PACK: begin
                word_next = {word_reg[mgc_pkg::CODE_W-DIGIT_BITS-1:0], gray_reg[idx_reg]};
                if (idx_reg != n_m1) begin
                    idx_next = idx_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                gray_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            idx_reg   <= '0;
            chunk_reg <= '0;
            mode_reg  <= mgc_pkg::MODE_LOAD;
            wrap_reg  <= 1'b0;
            chg_reg   <= '0;
            steps_reg <= '0;
            fin_reg   <= 1'b0;
        end else begin
            gray_reg  <= gray_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            chunk_reg <= chunk_next;
            mode_reg  <= mode_next;
            wrap_reg  <= wrap_next;
            chg_reg   <= chg_next;
            steps_reg <= steps_next;
            fin_reg   <= fin_next;
        end
        r_reg    <= r_next;
        rem_reg  <= rem_next;
        prev_reg <= prev_next;
        word_reg <= word_next;
    end

    assign stat.is_load  = (mode_reg == mgc_pkg::MODE_LOAD);
    assign stat.finished = fin_reg;
    assign stat.carry    = d_over && (idx_reg != '0);
    assign stat.div_last = (chunk_reg == CHUNK_LAST);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.idx_last = (idx_reg == n_m1);

    assign codeword = word_reg;
    assign changed  = chg_reg;
    assign steps    = steps_reg;
    assign finished = fin_reg;

endmodule

// ===== rtl/modular_gray_code_generator.sv =====
// load beat: the rank is divided by m digit by digit, 8 quotient bits per divider step, each
//   digit written after its last divider step, then the n digits are packed into the codeword
// advance beat: the carry ripples over the digits, then a digit is bumped unless the count wrapped;
//   both skipped when already done. one beat in flight, the output register frees the input side
// reset (aresetn low, synchronous): registers to 3, 3, 26, digits, step count and done cleared
`include "modular_gray_code_generator_assert.svh"

module modular_gray_code_generator #(
    parameter int MAX_DIGITS = mgc_pkg::MAX_DIGITS_DEF,
    parameter int DIGIT_BITS = mgc_pkg::DIGIT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mgc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [mgc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mgc_pkg::RANK_W-1:0]        s_tdata,   // start_rank
    input  logic                              s_tuser,   // mode
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // codeword[31:0], changed_position[35:32], step_count[67:36], done_res[68], zero pad
    output logic [mgc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int M_TOP = 1 << DIGIT_BITS;

    // configuration registers
    logic [mgc_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [mgc_pkg::WLEN_W-1:0]   wlen_reg;
    logic [mgc_pkg::LIMIT_W-1:0]  limit_reg;

    // effective m and n-1
    logic [mgc_pkg::ALPHA_W-1:0]  m_eff;
    logic [IDX_W-1:0]             n_m1;

    // sequencer and datapath
    mgc_pkg::op_t                 ctrl_op;
    mgc_pkg::stat_t               stat;
    logic                         in_fire;
    logic                         out_free;
    logic                         out_load;
    logic [mgc_pkg::CODE_W-1:0]   dp_code;
    logic [mgc_pkg::CHG_W-1:0]    dp_chg;
    logic [mgc_pkg::LIMIT_W-1:0]  dp_steps;
    logic                         dp_fin;

    // output register
    logic                         out_valid_reg;
    logic [mgc_pkg::CODE_W-1:0]   out_code_reg;
    logic [mgc_pkg::CHG_W-1:0]    out_chg_reg;
    logic [mgc_pkg::LIMIT_W-1:0]  out_steps_reg;
    logic                         out_fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= mgc_pkg::ALPHA_RST;
            wlen_reg  <= mgc_pkg::WLEN_RST;
            limit_reg <= mgc_pkg::LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mgc_pkg::CFG_ALPHABET: alpha_reg <= cfg_wdata[mgc_pkg::ALPHA_W-1:0];
                mgc_pkg::CFG_WORD_LEN: wlen_reg  <= cfg_wdata[mgc_pkg::WLEN_W-1:0];
                mgc_pkg::CFG_LIMIT:    limit_reg <= cfg_wdata[mgc_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp m to 2..2^DIGIT_BITS
    always_comb begin
        if (alpha_reg < mgc_pkg::ALPHA_W'(2)) begin
            m_eff = mgc_pkg::ALPHA_W'(2);
        end else if (32'(alpha_reg) > M_TOP) begin
            m_eff = mgc_pkg::ALPHA_W'(M_TOP);
        end else begin
            m_eff = alpha_reg;
        end
    end

    // clamp n to 1..MAX_DIGITS, kept as n-1 for indexing
    always_comb begin
        if (wlen_reg == '0) begin
            n_m1 = '0;
        end else if (32'(wlen_reg) > MAX_DIGITS) begin
            n_m1 = IDX_W'(MAX_DIGITS - 1);
        end else begin
            n_m1 = IDX_W'(wlen_reg - mgc_pkg::WLEN_W'(1));
        end
    end

    // handshakes: input only taken at the wait step of the program
    assign s_tready = (ctrl_op == mgc_pkg::OP_WAIT);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (ctrl_op == mgc_pkg::OP_EMIT) && out_free;

    mgc_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .op       (ctrl_op)
    );

    mgc_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (ctrl_op),
        .in_fire    (in_fire),
        .in_mode    (s_tuser),
        .in_rank    (s_tdata),
        .m_eff      (m_eff),
        .n_m1       (n_m1),
        .step_limit (limit_reg),
        .stat       (stat),
        .codeword   (dp_code),
        .changed    (dp_chg),
        .steps      (dp_steps),
        .finished   (dp_fin)
    );

    // result beat holds until taken; the program parks at emit while it is full and not taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_code_reg  <= dp_code;
            out_chg_reg   <= dp_chg;
            out_steps_reg <= dp_steps;
            out_fin_reg   <= dp_fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mgc_pkg::OUT_DATA_W'({out_fin_reg, out_steps_reg, out_chg_reg,
                                            out_code_reg});

    // one beat at a time through the program
    `MGC_ASSERT_NXT(a_single_beat, in_fire, !s_tready)
    // reported position never beyond the word length
    `MGC_ASSERT_IMP(a_chg_range, out_valid_reg, 32'(out_chg_reg) <= 32'(n_m1) + 32'd1)
    // a result appears only from the emit step
    `MGC_ASSERT_IMP(a_emit_src, $rose(out_valid_reg), $past(ctrl_op == mgc_pkg::OP_EMIT))

endmodule
